// ===== rtl/core/sm3_pkg.sv =====
package sm3_pkg;

   typedef logic [31:0] word_type;

   typedef struct packed {
      logic [31:0] data_word;
      logic [2:0]  byte_count;
      logic        msg_end;
   } req_item_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        digest_last;
   } rsp_item_type;

   typedef struct packed {
      logic push;
      logic start;
      logic round;
      logic finish;
      logic shift_out;
      logic reinit;
   } ctl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_COMP,
      ST_PAD,
      ST_OUT
   } state_type;

   localparam word_type T_LOW    = 32'h79cc4519;
   localparam word_type T_HIGH   = 32'h7a879d8a;
   localparam word_type PAD_WORD = 32'h80000000;
   localparam int       ROUNDS   = 64;

   localparam word_type SM3_IV [8] = '{
      32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
      32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e
   };

   function automatic word_type rol32(input word_type x, input logic [4:0] n);
      logic [63:0] tmp;
      tmp = {x, x} << n;
      return tmp[63:32];
   endfunction

   function automatic word_type perm0(input word_type x);
      return x ^ rol32(x, 5'd9) ^ rol32(x, 5'd17);
   endfunction

   function automatic word_type perm1(input word_type x);
      return x ^ rol32(x, 5'd15) ^ rol32(x, 5'd23);
   endfunction

   function automatic word_type round_const(input logic [5:0] j);
      word_type t;
      t = (j[5:4] == 2'd0) ? T_LOW : T_HIGH;
      return rol32(t, j[4:0]);
   endfunction

endpackage

// ===== rtl/core/sm3_sched.sv =====
module sm3_sched (
   input  logic              clock,
   input  sm3_pkg::ctl_type  ctl,
   input  sm3_pkg::word_type push_word,
   output sm3_pkg::word_type w_cur,
   output sm3_pkg::word_type wp_cur
);
   import sm3_pkg::*;

   word_type win_ff [16];
   word_type win_in [16];
   word_type expand;

   always_comb begin
      expand = perm1(win_ff[0] ^ win_ff[7] ^ rol32(win_ff[13], 5'd15))
             ^ rol32(win_ff[3], 5'd7) ^ win_ff[10];
      for (int i = 0; i < 16; i++) begin
         win_in[i] = win_ff[i];
      end
      if (ctl.push || ctl.round) begin
         for (int i = 0; i < 15; i++) begin
            win_in[i] = win_ff[i + 1];
         end
         win_in[15] = ctl.push ? push_word : expand;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 16; i++) begin
         win_ff[i] <= win_in[i];
      end
   end

   assign w_cur  = win_ff[0];
   assign wp_cur = win_ff[0] ^ win_ff[4];

endmodule

// ===== rtl/core/sm3_comp.sv =====
module sm3_comp (
   input  logic              clock,
   input  logic              reset,
   input  sm3_pkg::ctl_type  ctl,
   input  logic [5:0]        round_idx,
   input  sm3_pkg::word_type w_cur,
   input  sm3_pkg::word_type wp_cur,
   output sm3_pkg::word_type chain_word
);
   import sm3_pkg::*;

   word_type v_ff [8];
   word_type v_in [8];
   word_type nxt [8];
   word_type chain_ff [8];
   word_type chain_in [8];
   word_type a12, ss1, ss2, ffv, ggv, tt1, tt2;
   logic     early;

   always_comb begin
      early = (round_idx[5:4] == 2'd0);
      a12   = rol32(v_ff[0], 5'd12);
      ss1   = rol32(a12 + v_ff[4] + round_const(round_idx), 5'd7);
      ss2   = ss1 ^ a12;
      ffv   = early ? (v_ff[0] ^ v_ff[1] ^ v_ff[2])
                    : ((v_ff[0] & v_ff[1]) | (v_ff[0] & v_ff[2]) | (v_ff[1] & v_ff[2]));
      ggv   = early ? (v_ff[4] ^ v_ff[5] ^ v_ff[6])
                    : ((v_ff[4] & v_ff[5]) | (~v_ff[4] & v_ff[6]));
      tt1   = ffv + v_ff[3] + ss2 + wp_cur;
      tt2   = ggv + v_ff[7] + ss1 + w_cur;
      nxt[0] = tt1;
      nxt[1] = v_ff[0];
      nxt[2] = rol32(v_ff[1], 5'd9);
      nxt[3] = v_ff[2];
      nxt[4] = perm0(tt2);
      nxt[5] = v_ff[4];
      nxt[6] = rol32(v_ff[5], 5'd19);
      nxt[7] = v_ff[6];

      for (int i = 0; i < 8; i++) begin
         v_in[i]     = v_ff[i];
         chain_in[i] = chain_ff[i];
      end
      if (ctl.start) begin
         for (int i = 0; i < 8; i++) begin
            v_in[i] = chain_ff[i];
         end
      end else if (ctl.round) begin
         for (int i = 0; i < 8; i++) begin
            v_in[i] = nxt[i];
         end
      end
      if (ctl.reinit) begin
         for (int i = 0; i < 8; i++) begin
            chain_in[i] = SM3_IV[i];
         end
      end else if (ctl.finish) begin
         for (int i = 0; i < 8; i++) begin
            chain_in[i] = chain_ff[i] ^ nxt[i];
         end
      end else if (ctl.shift_out) begin
         for (int i = 0; i < 7; i++) begin
            chain_in[i] = chain_ff[i + 1];
         end
         chain_in[7] = chain_ff[0];
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 8; i++) begin
         v_ff[i] <= v_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 8; i++) begin
            chain_ff[i] <= SM3_IV[i];
         end
      end else begin
         for (int i = 0; i < 8; i++) begin
            chain_ff[i] <= chain_in[i];
         end
      end
   end

   assign chain_word = chain_ff[0];

endmodule

// ===== rtl/core/sm3_hash_engine.sv =====
// SM3 hash engine with a 256-bit digest.
// The request channel carries one message word per item, first byte in bits
// 31..24. The final word of a message has msg_end set and byte_count giving
// its valid bytes from the high end, zero to four.
// A word that does not complete a 16-word block is taken without a stall. The
// word that completes a block starts the compression, which runs one round
// per cycle on a single shared round unit; no new word is taken until the
// compression of the block is through.
// After the final word the engine pushes padding and the bit length at one
// word per cycle outside of compression and compresses one or two more
// blocks. The eight digest words then leave on the response channel, most
// significant first, with digest_last on the eighth.
// The request stall is high during each compression and, after
// the final word, until the last digest word is taken. A stalled response
// holds its item; the engine waits.
// Reset loads the initial vector and clears the length and word position;
// the block is ready in the cycle after reset falls.
module sm3_hash_engine (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  sm3_pkg::req_item_type req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output sm3_pkg::rsp_item_type rsp_item
);
   import sm3_pkg::*;

   state_type   state_ff, state_in;
   logic [3:0]  pos_ff, pos_in;
   logic [60:0] len_ff, len_in;
   logic [5:0]  round_ff, round_in;
   logic [2:0]  idx_ff, idx_in;
   logic        fin_ff, fin_in;
   logic        extra_ff, extra_in;
   logic        hi_ff, hi_in;
   logic        done_ff, done_in;
   ctl_type     ctl;
   word_type    push_word;
   word_type    w_cur, wp_cur, chain_word;
   logic [2:0]  cnt;
   word_type    keep_mask, pad_bits;

   always_comb begin
      cnt = (req_item.byte_count > 3'd4) ? 3'd4 : req_item.byte_count;
      case (cnt)
         3'd0: begin
            keep_mask = 32'h00000000;
            pad_bits  = 32'h80000000;
         end
         3'd1: begin
            keep_mask = 32'hff000000;
            pad_bits  = 32'h00800000;
         end
         3'd2: begin
            keep_mask = 32'hffff0000;
            pad_bits  = 32'h00008000;
         end
         3'd3: begin
            keep_mask = 32'hffffff00;
            pad_bits  = 32'h00000080;
         end
         default: begin
            keep_mask = 32'hffffffff;
            pad_bits  = 32'h00000000;
         end
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      len_in    = len_ff;
      round_in  = round_ff;
      idx_in    = idx_ff;
      fin_in    = fin_ff;
      extra_in  = extra_ff;
      hi_in     = hi_ff;
      done_in   = done_ff;
      ctl       = '0;
      push_word = req_item.data_word;
      req_stall = 1'b1;
      rsp_valid = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               ctl.push = 1'b1;
               if (!req_item.msg_end) begin
                  len_in = len_ff + 61'd4;
               end else begin
                  len_in    = len_ff + 61'(cnt);
                  push_word = (req_item.data_word & keep_mask) | pad_bits;
                  extra_in  = (cnt == 3'd4);
                  fin_in    = 1'b1;
                  hi_in     = 1'b0;
                  done_in   = 1'b0;
               end
               if (pos_ff == 4'd15) begin
                  ctl.start = 1'b1;
                  round_in  = '0;
                  state_in  = ST_COMP;
               end else if (req_item.msg_end) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            ctl.push = 1'b1;
            if (extra_ff) begin
               push_word = PAD_WORD;
               extra_in  = 1'b0;
            end else if (hi_ff) begin
               push_word = {len_ff[28:0], 3'b000};
               done_in   = 1'b1;
            end else if (pos_ff == 4'd14) begin
               push_word = len_ff[60:29];
               hi_in     = 1'b1;
            end else begin
               push_word = '0;
            end
            if (pos_ff == 4'd15) begin
               ctl.start = 1'b1;
               round_in  = '0;
               state_in  = ST_COMP;
            end
         end
         ST_COMP: begin
            ctl.round = 1'b1;
            round_in  = round_ff + 6'd1;
            if (round_ff == 6'(ROUNDS - 1)) begin
               ctl.finish = 1'b1;
               if (done_ff) begin
                  idx_in   = '0;
                  state_in = ST_OUT;
               end else if (fin_ff) begin
                  state_in = ST_PAD;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               ctl.shift_out = 1'b1;
               idx_in        = idx_ff + 3'd1;
               if (idx_ff == 3'd7) begin
                  ctl.reinit = 1'b1;
                  len_in     = '0;
                  fin_in     = 1'b0;
                  hi_in      = 1'b0;
                  done_in    = 1'b0;
                  extra_in   = 1'b0;
                  state_in   = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      pos_in = ctl.push ? pos_ff + 4'd1 : pos_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pos_ff   <= '0;
         len_ff   <= '0;
         round_ff <= '0;
         idx_ff   <= '0;
         fin_ff   <= 1'b0;
         extra_ff <= 1'b0;
         hi_ff    <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         len_ff   <= len_in;
         round_ff <= round_in;
         idx_ff   <= idx_in;
         fin_ff   <= fin_in;
         extra_ff <= extra_in;
         hi_ff    <= hi_in;
         done_ff  <= done_in;
      end
   end

   sm3_sched u_sched (
      .clock     (clock),
      .ctl       (ctl),
      .push_word (push_word),
      .w_cur     (w_cur),
      .wp_cur    (wp_cur)
   );

   sm3_comp u_comp (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .round_idx  (round_ff),
      .w_cur      (w_cur),
      .wp_cur     (wp_cur),
      .chain_word (chain_word)
   );

   assign rsp_item.digest_word = chain_word;
   assign rsp_item.word_index  = idx_ff;
   assign rsp_item.digest_last = (idx_ff == 3'd7);

endmodule

// ===== rtl/core/sm3_checker.sv =====
module sm3_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input sm3_pkg::rsp_item_type rsp_item
);
   import sm3_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
      else $error("Stalled response item changed.");

   a_busy_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("Request taken while the digest is being sent.");

   a_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_item.digest_last |=>
         rsp_valid && rsp_item.word_index == $past(rsp_item.word_index) + 3'd1)
      else $error("Digest words not sent in order without gaps.");

   a_burst_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_item.digest_last |=> !rsp_valid)
      else $error("Response continued after the last digest word.");

endmodule

bind sm3_hash_engine sm3_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_item  (rsp_item)
);

// ===== bench/tb.sv =====
module tb;
   import sm3_pkg::*;

   localparam int TOTAL_ITEMS    = 260;
   localparam int CALM_TAIL      = 40;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 200;

   localparam word_type TJ_EARLY = 32'h79cc4519;
   localparam word_type TJ_LATE  = 32'h7a879d8a;
   localparam word_type PAD_MARK = 32'h80000000;
   localparam word_type START_CV [8] = '{
      32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
      32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e
   };

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_item_type req_item = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_item_type rsp_item;

   sm3_hash_engine u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   req_item_type pending_words[$];
   rsp_item_type expected_digest[$];

   word_type    msg_block[16];
   word_type    chain_cv[8];
   logic [60:0] msg_bytes;
   int unsigned block_fill;

   logic req_taken = 1'b0;
   logic random_phase = 1'b0;
   int   req_gap = 0;
   int   stall_left = 0;
   int   idle_cycles = 0;
   int   errors = 0;
   int   words_sent = 0;
   int   words_checked = 0;
   int   messages_queued = 0;
   int   items_queued = 0;

   function automatic word_type rotl(input word_type x, input int unsigned n);
      int unsigned s;
      s = n % 32;
      if (s == 0) return x;
      return (x << s) | (x >> (32 - s));
   endfunction

   function automatic word_type mix_p0(input word_type x);
      return x ^ rotl(x, 9) ^ rotl(x, 17);
   endfunction

   function automatic word_type mix_p1(input word_type x);
      return x ^ rotl(x, 15) ^ rotl(x, 23);
   endfunction

   task automatic compress_block();
      word_type w[68];
      word_type wp[64];
      word_type a, b, c, d, e, f, g, h;
      word_type a12, ss1, ss2, ff, gg, tt1, tt2, tj;
      for (int j = 0; j < 16; j++) w[j] = msg_block[j];
      for (int j = 16; j < 68; j++)
         w[j] = mix_p1(w[j-16] ^ w[j-9] ^ rotl(w[j-3], 15)) ^ rotl(w[j-13], 7) ^ w[j-6];
      for (int j = 0; j < 64; j++) wp[j] = w[j] ^ w[j+4];
      a = chain_cv[0]; b = chain_cv[1]; c = chain_cv[2]; d = chain_cv[3];
      e = chain_cv[4]; f = chain_cv[5]; g = chain_cv[6]; h = chain_cv[7];
      for (int j = 0; j < 64; j++) begin
         tj  = (j < 16) ? TJ_EARLY : TJ_LATE;
         a12 = rotl(a, 12);
         ss1 = rotl(a12 + e + rotl(tj, j), 7);
         ss2 = ss1 ^ a12;
         ff  = (j < 16) ? (a ^ b ^ c) : ((a & b) | (a & c) | (b & c));
         gg  = (j < 16) ? (e ^ f ^ g) : ((e & f) | (~e & g));
         tt1 = ff + d + ss2 + wp[j];
         tt2 = gg + h + ss1 + w[j];
         d = c;
         c = rotl(b, 9);
         b = a;
         a = tt1;
         h = g;
         g = rotl(f, 19);
         f = e;
         e = mix_p0(tt2);
      end
      chain_cv[0] ^= a; chain_cv[1] ^= b; chain_cv[2] ^= c; chain_cv[3] ^= d;
      chain_cv[4] ^= e; chain_cv[5] ^= f; chain_cv[6] ^= g; chain_cv[7] ^= h;
   endtask

   task automatic absorb_word(input word_type wd);
      msg_block[block_fill] = wd;
      block_fill = (block_fill + 1) % 16;
      if (block_fill == 0) compress_block();
   endtask

   task automatic restart_digest();
      chain_cv   = START_CV;
      msg_bytes  = '0;
      block_fill = 0;
   endtask

   task automatic predict_digest(input req_item_type it);
      int unsigned   n;
      word_type      keep;
      logic [63:0]   bit_len;
      rsp_item_type  r;
      if (!it.msg_end) begin
         msg_bytes = msg_bytes + 61'd4;
         absorb_word(it.data_word);
      end else begin
         n = (it.byte_count > 3'd4) ? 4 : it.byte_count;
         msg_bytes = msg_bytes + 61'(n);
         if (n == 4) begin
            absorb_word(it.data_word);
            absorb_word(PAD_MARK);
         end else begin
            keep = (n == 0) ? 32'h0 : (32'hffffffff << (32 - 8 * n));
            absorb_word((it.data_word & keep) | (PAD_MARK >> (8 * n)));
         end
         while (block_fill != 14) absorb_word(32'h0);
         bit_len = {msg_bytes, 3'b000};
         absorb_word(bit_len[63:32]);
         absorb_word(bit_len[31:0]);
         for (int k = 0; k < 8; k++) begin
            r.digest_word = chain_cv[k];
            r.word_index  = 3'(k);
            r.digest_last = (k == 7);
            expected_digest.push_back(r);
         end
         restart_digest();
      end
   endtask

   task automatic check_digest_word(input rsp_item_type got);
      rsp_item_type want;
      words_checked++;
      if (expected_digest.size() == 0) begin
         $error("Digest word %h arrived with no digest pending", got.digest_word);
         errors++;
      end else begin
         want = expected_digest.pop_front();
         if (got.digest_word !== want.digest_word) begin
            $error("digest_word: expected %h, actual %h", want.digest_word, got.digest_word);
            errors++;
         end
         if (got.word_index !== want.word_index) begin
            $error("word_index: expected %0d, actual %0d", want.word_index, got.word_index);
            errors++;
         end
         if (got.digest_last !== want.digest_last) begin
            $error("digest_last: expected %0d, actual %0d", want.digest_last, got.digest_last);
            errors++;
         end
      end
   endtask

   task automatic push_item(input word_type wd, input logic [2:0] cnt, input logic fin);
      req_item_type it;
      it.data_word  = wd;
      it.byte_count = cnt;
      it.msg_end    = fin;
      pending_words.push_back(it);
      items_queued++;
      if (fin) messages_queued++;
   endtask

   task automatic queue_message(input int unsigned body_words, input logic [2:0] last_count);
      for (int unsigned i = 0; i < body_words; i++)
         push_item($urandom, 3'($urandom_range(0, 7)), 1'b0);
      push_item($urandom, last_count, 1'b1);
   endtask

   initial begin
      forever #10 clock = ~clock;
   end

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (req_gap != 0) begin
            req_gap   <= req_gap - 1;
            req_valid <= 1'b0;
         end else if (pending_words.size() != 0) begin
            if (!(random_phase && pending_words.size() < CALM_TAIL)
                && $urandom_range(0, 9) == 0) begin
               req_gap   <= $urandom_range(0, 6);
               req_valid <= 1'b0;
            end else begin
               req_item  <= pending_words.pop_front();
               req_valid <= 1'b1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= 1'b1;
      end else if (!(random_phase && pending_words.size() < CALM_TAIL)
                   && $urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(0, 6);
         rsp_stall  <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            predict_digest(req_item);
            words_sent++;
         end
         if (rsp_valid && !rsp_stall) check_digest_word(rsp_item);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   initial begin
      int unsigned body;
      restart_digest();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Empty message, with the unused data bits all set.
      push_item(32'hffffffff, 3'd0, 1'b1);
      push_item(32'h61626300, 3'd3, 1'b1);
      push_item(32'hffffffff, 3'd1, 1'b1);
      push_item(32'h00000000, 3'd2, 1'b1);
      // The byte count on a word that is not final is ignored.
      push_item(32'hffffffff, 3'd7, 1'b0);
      push_item(32'hffffffff, 3'd4, 1'b1);
      // Counts above four on the final word act as four.
      push_item($urandom, 3'd5, 1'b1);
      push_item($urandom, 3'd6, 1'b1);
      // The padding no longer fits, so a second block is needed.
      queue_message(13, 3'd4);

      while (pending_words.size() != 0 || req_valid) @(posedge clock);
      while (expected_digest.size() != 0) @(posedge clock);

      random_phase = 1'b1;
      while (items_queued < TOTAL_ITEMS) begin
         body = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 40) : $urandom_range(0, 18);
         queue_message(body, 3'($urandom_range(0, 7)));
      end

      while (pending_words.size() != 0 || req_valid) @(posedge clock);
      while (expected_digest.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Hashed %0d messages from %0d words, empty, short, padded and two-block tails.",
               messages_queued, words_sent);
      $display("Checked %0d digest words; %0d mismatches.", words_checked, errors);
      if (errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
